>>> rtl/lcsl_pkg.sv
// ----------------------------------------------------------------------------
// lcsl_pkg
// Shared types and constants for the lidar corridor speed limiter.
// ----------------------------------------------------------------------------
package lcsl_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_ONE_K = 34'sd652032874;

	// floor(n * 2^30 / 700) = n * WHOLE + ((n * FRAC) >> SHIFT), exact for n <= 450
	localparam logic [41:0] DIV700_WHOLE = 42'd1533916;
	localparam logic [41:0] DIV700_FRAC  = 42'd14955720;
	localparam int          DIV700_SHIFT = 24;

	localparam logic [2:0] REG_INVERT_SWEEP   = 3'd0;
	localparam logic [2:0] REG_HEADING_OFFSET = 3'd1;
	localparam logic [2:0] REG_CORRIDOR_WIDTH = 3'd2;
	localparam logic [2:0] REG_SCAN_START     = 3'd3;
	localparam logic [2:0] REG_SCAN_STEP      = 3'd4;

	// queue entry from front to back
	typedef struct packed {
		logic        motion;
		logic [15:0] range_mm;
		logic        last_sample;
		logic [15:0] vel_x;
		logic [15:0] vel_y;
		logic [15:0] beam;
	} lcsl_job_t;

	function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
		case (i)
			4'd0: atan_turn = 34'sd536870912;
			4'd1: atan_turn = 34'sd316933406;
			4'd2: atan_turn = 34'sd167458907;
			4'd3: atan_turn = 34'sd85004756;
			4'd4: atan_turn = 34'sd42667331;
			4'd5: atan_turn = 34'sd21354465;
			4'd6: atan_turn = 34'sd10679838;
			4'd7: atan_turn = 34'sd5340245;
			4'd8: atan_turn = 34'sd2670163;
			4'd9: atan_turn = 34'sd1335087;
			4'd10: atan_turn = 34'sd667544;
			4'd11: atan_turn = 34'sd333772;
			4'd12: atan_turn = 34'sd166886;
			4'd13: atan_turn = 34'sd83443;
			4'd14: atan_turn = 34'sd41722;
			4'd15: atan_turn = 34'sd20861;
			default: atan_turn = '0;
		endcase
	endfunction

endpackage

>>> rtl/lcsl_front.sv
// ----------------------------------------------------------------------------
// lcsl_front
// Accepts items, tracks the sample index and forms the beam angle.
// ----------------------------------------------------------------------------
module lcsl_front #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcsl_pkg::lcsl_job_t in_job,
	input  logic                invert_sweep,
	input  logic [15:0]         heading_offset,
	input  logic [15:0]         scan_start_angle,
	input  logic [15:0]         scan_step_angle,
	output logic                q_valid,
	input  logic                q_ready,
	output lcsl_pkg::lcsl_job_t q_job
);
	import lcsl_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES);

	logic [CW-1:0] cnt_q;
	logic          vld_q;
	lcsl_job_t     job_q;
	lcsl_job_t     job_d;
	logic [15:0]   idx16;
	logic [15:0]   prod;
	logic [15:0]   base;
	logic          acc;

	assign in_ready = !vld_q || q_ready;
	assign acc      = in_valid && in_ready;
	assign q_valid  = vld_q;
	assign q_job    = job_q;

	always_comb begin
		idx16 = 16'(cnt_q);
		prod  = 16'(scan_step_angle * idx16);
		base  = heading_offset + scan_start_angle;
		job_d = in_job;
		job_d.beam = invert_sweep ? base - prod : base + prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (acc) begin
				vld_q <= 1'b1;
				if (!in_job.motion) begin
					if (in_job.last_sample)
						cnt_q <= '0;
					else if (cnt_q != CW'(MAX_SAMPLES - 1))
						cnt_q <= cnt_q + 1'b1;
				end
			end else if (q_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			job_q <= job_d;
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !q_ready |=> vld_q && $stable(job_q))
		else $error("queued job lost");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !in_job.motion && in_job.last_sample |=> cnt_q == '0)
		else $error("index not cleared");
	a_motion: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_job.motion |=> $stable(cnt_q))
		else $error("motion moved index");
`endif
endmodule

>>> rtl/lcsl_back.sv
// ----------------------------------------------------------------------------
// lcsl_back
// Runs CORDIC atan2 / sin and the bitwise isqrt, keeps the scan minimum.
// ----------------------------------------------------------------------------
module lcsl_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  lcsl_pkg::lcsl_job_t q_job,
	input  logic [15:0]         corridor_width_mm,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         multiplier,
	output logic                obstacle_close
);
	import lcsl_pkg::*;

	localparam int SH = 32 - ANGLE_BITS;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ATAN = 6'b000010,
		ST_SIN  = 6'b000100,
		ST_TEST = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_DONE = 6'b100000
	} st_t;

	st_t                     st_q;
	logic [3:0]              it_q;
	logic signed [33:0]      x_q, y_q, z_q;
	logic [31:0]             abase_q;
	logic [ANGLE_BITS-1:0]   heading_q;
	logic [15:0]             rmin_q;
	logic                    close_q;
	lcsl_job_t               job_q;
	logic [41:0]             sq_v_q;
	logic [41:0]             sq_res_q;
	logic [41:0]             sq_bit_q;
	logic                    ovld_q;
	logic [15:0]             omul_q;
	logic                    oclose_q;

	logic signed [33:0]      dx, dy;
	logic [ANGLE_BITS-1:0]   d;
	logic [ANGLE_BITS-1:0]   mag;
	logic [ANGLE_BITS+2:0]   mag6;
	logic signed [33:0]      zd;
	logic [31:0]             afin;
	logic [33:0]             ay;
	logic [51:0]             lhs;
	logic [45:0]             rhs;
	logic [15:0]             rr;
	logic [8:0]              nrm;
	logic [41:0]             qv;
	logic [41:0]             trial;

	assign q_ready        = (st_q == ST_IDLE) && !ovld_q;
	assign out_valid      = ovld_q;
	assign multiplier     = omul_q;
	assign obstacle_close = oclose_q;

	always_comb begin
		dx   = y_q >>> it_q;
		dy   = x_q >>> it_q;
		d    = ANGLE_BITS'((32'(q_job.beam) << 16) >> SH) - heading_q;
		mag  = d[ANGLE_BITS-1] ? ANGLE_BITS'(0) - d : d;
		mag6 = (ANGLE_BITS+3)'(mag) * (ANGLE_BITS+3)'(6);
		zd   = 34'(signed'(d)) <<< SH;
		afin = abase_q + 32'(z_q) + (32'd1 << (SH - 1));
		ay   = y_q[33] ? 34'(-y_q) : 34'(y_q);
		lhs  = 52'(job_q.range_mm) * 52'(ay) * 52'd2;
		rhs  = 46'(corridor_width_mm) << 30;
		rr   = (job_q.range_mm < 16'd250) ? 16'd250 : job_q.range_mm;
		nrm  = 9'(rr - 16'd250);
		qv   = 42'(nrm) * DIV700_WHOLE + ((42'(nrm) * DIV700_FRAC) >> DIV700_SHIFT);
		trial = sq_res_q + sq_bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			heading_q <= '0;
			rmin_q    <= 16'd32768;
			close_q   <= 1'b0;
			ovld_q    <= 1'b0;
			omul_q    <= '0;
			oclose_q  <= 1'b0;
			it_q      <= '0;
		end else begin
			if (ovld_q && out_ready)
				ovld_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						it_q <= '0;
						if (q_job.motion) begin
							if (q_job.vel_x != '0 || q_job.vel_y != '0)
								st_q <= ST_ATAN;
						end else if (q_job.range_mm <= 16'd700 &&
								(ANGLE_BITS+3)'(mag6) < (ANGLE_BITS+3)'(1 << ANGLE_BITS)) begin
							st_q <= ST_SIN;
						end else begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_ATAN: begin
					it_q <= it_q + 1'b1;
					if (it_q == 4'(CORDIC_STEPS - 1))
						st_q <= ST_DONE;
				end
				ST_SIN: begin
					it_q <= it_q + 1'b1;
					if (it_q == 4'(CORDIC_STEPS - 1))
						st_q <= ST_TEST;
				end
				ST_TEST: begin
					if (lhs < 52'(rhs)) begin
						st_q <= ST_SQRT;
						if (job_q.range_mm < 16'd300)
							close_q <= 1'b1;
					end else begin
						st_q <= ST_DONE;
					end
				end
				ST_SQRT: begin
					if (sq_bit_q == '0) begin
						if (sq_res_q[15:0] < rmin_q)
							rmin_q <= sq_res_q[15:0];
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (job_q.motion) begin
						if (job_q.vel_x != '0 || job_q.vel_y != '0)
							heading_q <= afin[31 -: ANGLE_BITS];
						st_q <= ST_IDLE;
					end else if (job_q.last_sample) begin
						if (!ovld_q) begin
							ovld_q   <= 1'b1;
							omul_q   <= rmin_q;
							oclose_q <= close_q;
							rmin_q   <= 16'd32768;
							close_q  <= 1'b0;
							st_q     <= ST_IDLE;
						end
					end else begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_valid && q_ready) begin
					job_q <= q_job;
					if (q_job.motion) begin
						if (q_job.vel_x[15]) begin
							x_q <= -(34'(signed'(q_job.vel_x)) <<< 14);
							y_q <= -(34'(signed'(q_job.vel_y)) <<< 14);
							abase_q <= 32'h8000_0000;
						end else begin
							x_q <= 34'(signed'(q_job.vel_x)) <<< 14;
							y_q <= 34'(signed'(q_job.vel_y)) <<< 14;
							abase_q <= '0;
						end
						z_q <= '0;
					end else begin
						x_q <= CORDIC_ONE_K;
						y_q <= '0;
						z_q <= zd;
					end
				end
			end
			ST_ATAN: begin
				if (!y_q[33]) begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_turn(it_q);
				end else begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_turn(it_q);
				end
			end
			ST_SIN: begin
				if (!z_q[33]) begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_turn(it_q);
				end else begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_turn(it_q);
				end
			end
			ST_TEST: begin
				sq_v_q   <= qv;
				sq_res_q <= '0;
				sq_bit_q <= 42'd1 << 30;
			end
			ST_SQRT: begin
				if (sq_bit_q != '0) begin
					if (sq_v_q >= trial) begin
						sq_v_q   <= sq_v_q - trial;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !out_ready |=> ovld_q && $stable(omul_q))
		else $error("result dropped");
	a_rmin: assert property (@(posedge clk) disable iff (!arst_n)
		rmin_q <= 16'd32768)
		else $error("minimum out of range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !q_ready)
		else $error("queue taken while busy");
`endif
endmodule

>>> rtl/lidar_corridor_speed_limiter_unit.sv
// ----------------------------------------------------------------------------
// lidar_corridor_speed_limiter_unit
// Per-scan speed multiplier from lidar samples and motion heading.
// ----------------------------------------------------------------------------
// Sequence: a sample beyond 700 mm or 60 degrees goes from the queue to done;
//   one failing the corridor test takes queue, 16 CORDIC sin, test, done; one
//   in path adds a 16-step isqrt before done; a nonzero motion item sets heading.
// The back engine takes one item at a time; the front holds one more; a
//   result waiting on the output stalls the back.
// Reset: arst_n clears heading, scan min (1.0), close flag, index; sets reg defaults.
module lidar_corridor_speed_limiter_unit #(
	parameter int MAX_SAMPLES = 4096,
	parameter int ANGLE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // range_mm, vel_x, vel_y
	input  logic        s_axis_tlast,  // last_sample
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // multiplier
	output logic        m_axis_tuser,  // obstacle_close
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lcsl_pkg::*;

	logic        invert_sweep_q;
	logic [15:0] heading_offset_q, corridor_width_q, scan_start_q, scan_step_q;
	lcsl_job_t   in_job, q_job;
	logic        q_valid, q_ready;

	always_comb begin
		in_job.motion      = s_axis_tuser;
		in_job.range_mm    = s_axis_tdata[15:0];
		in_job.last_sample = s_axis_tlast;
		in_job.vel_x       = s_axis_tdata[31:16];
		in_job.vel_y       = s_axis_tdata[47:32];
		in_job.beam        = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_sweep_q   <= 1'b1;
			heading_offset_q <= '0;
			corridor_width_q <= 16'd300;
			scan_start_q     <= '0;
			scan_step_q      <= 16'd182;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INVERT_SWEEP:   invert_sweep_q   <= cfg_data[0];
				REG_HEADING_OFFSET: heading_offset_q <= cfg_data;
				REG_CORRIDOR_WIDTH: corridor_width_q <= cfg_data;
				REG_SCAN_START:     scan_start_q     <= cfg_data;
				REG_SCAN_STEP:      scan_step_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	lcsl_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job,
		.invert_sweep(invert_sweep_q), .heading_offset(heading_offset_q),
		.scan_start_angle(scan_start_q), .scan_step_angle(scan_step_q),
		.q_valid, .q_ready, .q_job
	);

	lcsl_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_job,
		.corridor_width_mm(corridor_width_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.multiplier(m_axis_tdata), .obstacle_close(m_axis_tuser)
	);
endmodule

>>> tb/tb_lidar_corridor_speed_limiter_unit.sv
// ----------------------------------------------------------------------------
// tb_lidar_corridor_speed_limiter_unit
// Self-checking bench for the lidar corridor speed limiter. A table of
// directed items hits range and velocity extremes and the zero-velocity and
// zero-range cases; a zero corridor comes next. Random scans and motion
// items follow under several register settings. A bit-accurate predictor
// computes each scan's multiplier and close flag. Both stream sides stall at
// random, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_lidar_corridor_speed_limiter_unit;
	import lcsl_pkg::*;

	typedef struct {
		bit          motion;
		bit [15:0]   range_mm;
		bit          last;
		bit [15:0]   vx;
		bit [15:0]   vy;
		bit          typed;
		bit [15:0]   mult;
		bit          close;
	} row_t;

	typedef struct {
		bit [15:0] mult;
		bit        close;
	} scan_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] in_fields;
	logic        s_axis_tlast;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	lidar_corridor_speed_limiter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(in_fields),       // range_mm, vel_x, vel_y
		.s_axis_tlast(s_axis_tlast),    // last_sample
		.s_axis_tuser(s_axis_tuser),    // mode
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),    // multiplier
		.m_axis_tuser(m_axis_tuser),    // obstacle_close
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register mirror and block state
	bit        invert_sweep;
	bit [15:0] heading_offset, corridor_width, scan_start, scan_step;
	bit [15:0] heading, scan_min;
	bit        close_seen;
	bit [11:0] sample_idx;

	scan_res_t scan_results[$];
	bit        pending_typed[$];
	scan_res_t pending_vals[$];
	int        errors, n_in, n_out, n_hits;
	int        max_gap;
	bit        hold_long;
	int        idle_cycles;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_out);
		errors++;
	endtask

	function automatic longint sine_q30(input longint z);
		longint x, y, dx, dy;
		x = CORDIC_ONE_K;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i[3:0]));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i[3:0]));
			end
		end
		return y;
	endfunction

	function automatic bit [15:0] heading_of(input longint vx, input longint vy);
		longint x, y, z, dx, dy;
		bit [31:0] a;
		x = vx * 16384;
		y = vy * 16384;
		z = 0;
		a = 0;
		if (x < 0) begin
			x = -x; y = -y; a = 32'h8000_0000;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(atan_turn(i[3:0]));
			end else begin
				x -= dx; y += dy; z -= longint'(atan_turn(i[3:0]));
			end
		end
		a = a + z[31:0] + 32'd32768;
		return a[31:16];
	endfunction

	function automatic bit [15:0] root_of(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res[15:0];
	endfunction

	// advances the scan state for one accepted item; returns 1 on a result
	function automatic bit scan_step_predict(input bit motion, input bit [15:0] r,
			input bit last, input bit [15:0] vx, input bit [15:0] vy,
			output scan_res_t res);
		bit [15:0] prod, beam, d, mag;
		longint zd, y;
		longint unsigned ay, rr, q;
		res = '{0, 0};
		if (motion) begin
			if (vx != 0 || vy != 0)
				heading = heading_of(longint'(signed'(vx)), longint'(signed'(vy)));
			return 0;
		end
		if (r <= 700) begin
			prod = scan_step * {4'd0, sample_idx};
			beam = heading_offset + scan_start;
			beam = invert_sweep ? beam - prod : beam + prod;
			d = beam - heading;
			mag = d[15] ? 16'(-d) : d;
			if (32'(mag) * 6 < 32'd65536) begin
				zd = longint'(signed'(d));
				y = sine_q30(zd <<< 16);
				ay = y < 0 ? -y : y;
				if (2 * longint'(r) * ay < (longint'(corridor_width) << 30)) begin
					rr = r < 250 ? 250 : r;
					q = ((rr - 250) << 30) / 700;
					n_hits++;
					if (r < 300) close_seen = 1;
					if (root_of(q) < scan_min) scan_min = root_of(q);
				end
			end
		end
		if (last) begin
			res = '{scan_min, close_seen};
			scan_min = 16'd32768;
			close_seen = 0;
			sample_idx = 0;
			return 1;
		end
		if (sample_idx != 12'hFFF) sample_idx++;
		return 0;
	endfunction

	always @(posedge clk) begin
		scan_res_t r;
		if (s_axis_tvalid && s_axis_tready) begin
			n_in++;
			if (scan_step_predict(s_axis_tuser, in_fields[15:0], s_axis_tlast,
					in_fields[31:16], in_fields[47:32], r)) begin
				if (pending_typed.size() != 0 && pending_typed[0])
					r = pending_vals[0];
				scan_results.push_back(r);
			end
			if (pending_typed.size() != 0) begin
				void'(pending_typed.pop_front());
				void'(pending_vals.pop_front());
			end
		end
		if (m_axis_tvalid && m_axis_tready) begin
			n_out++;
			if (scan_results.size() == 0) begin
				$display("unexpected result mult %0d", m_axis_tdata);
				errors++;
			end else begin
				r = scan_results.pop_front();
				if (m_axis_tdata !== r.mult) report("multiplier", m_axis_tdata, r.mult);
				if (m_axis_tuser !== r.close) report("close flag", m_axis_tuser, r.close);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("timeout");
			$display("tb_lidar_corridor_speed_limiter_unit: errors");
			$finish;
		end
	end

	// result receiver
	initial begin
		int w;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			w = hold_long ? 400 : $urandom_range(0, max_gap);
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	task automatic send(input bit motion, input bit [15:0] r, input bit last,
			input bit [15:0] vx, input bit [15:0] vy);
		int w;
		w = $urandom_range(0, max_gap);
		if (w > 0) begin
			s_axis_tvalid <= 0;
			repeat (w) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= motion;
		s_axis_tlast <= last;
		in_fields <= {vy, vx, r};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (scan_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input bit [2:0] idx, input bit [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_INVERT_SWEEP:   invert_sweep = val[0];
			REG_HEADING_OFFSET: heading_offset = val;
			REG_CORRIDOR_WIDTH: corridor_width = val;
			REG_SCAN_START:     scan_start = val;
			REG_SCAN_STEP:      scan_step = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int items);
		bit [15:0] r;
		int k;
		for (k = 0; k < items; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 5) == 0) send(1, 16'($urandom), 0, 0, 0);
				else send(1, 16'($urandom), 1'($urandom_range(0, 1)),
						16'($urandom), 16'($urandom));
			end else begin
				case ($urandom_range(0, 7))
					0: r = 16'($urandom);
					1: r = 16'($urandom_range(0, 300));
					default: r = 16'($urandom_range(0, 800));
				endcase
				send(0, r, $urandom_range(0, 5) == 0, 0, 0);
			end
		end
		send(0, 16'($urandom_range(0, 800)), 1, 0, 0);
	endtask

	row_t dir_rows[] = '{
		'{0, 16'd800,   1, 0, 0, 1, 16'd32768, 0},
		'{0, 16'd0,     1, 0, 0, 1, 16'd0,     1},
		'{0, 16'd65535, 1, 0, 0, 1, 16'd32768, 0},
		'{1, 16'd65535, 1, 0, 0, 0, 0, 0},
		'{0, 16'd0,     1, 0, 0, 1, 16'd0,     1},
		'{1, 0, 0, 16'h7FFF, 16'h0000, 0, 0, 0},
		'{1, 0, 0, 16'h8000, 16'h8000, 0, 0, 0},
		'{0, 16'd400,   0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 16'h0000, 16'h7FFF, 0, 0, 0},
		'{1, 0, 0, 16'hFFFF, 16'h0000, 0, 0, 0},
		'{1, 0, 0, 16'h0000, 16'h8000, 0, 0, 0},
		'{1, 0, 0, 16'h0001, 16'hFFFF, 0, 0, 0},
		'{1, 0, 0, 16'h7FFF, 16'h7FFF, 0, 0, 0},
		'{0, 16'd500,   1, 0, 0, 0, 0, 0},
		'{1, 0, 0, 16'd100, 16'd0, 0, 0, 0},
		'{0, 16'd250,   0, 0, 0, 0, 0, 0},
		'{0, 16'd299,   0, 0, 0, 0, 0, 0},
		'{0, 16'd300,   0, 0, 0, 0, 0, 0},
		'{0, 16'd700,   0, 0, 0, 0, 0, 0},
		'{0, 16'd701,   1, 0, 0, 0, 0, 0},
		'{0, 16'd700,   1, 0, 0, 0, 0, 0},
		'{0, 16'd249,   1, 0, 0, 0, 0, 0}
	};

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tlast = 0;
		s_axis_tuser = 0;
		in_fields = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		max_gap = 8;
		hold_long = 0;
		idle_cycles = 0;
		invert_sweep = 1;
		heading_offset = 0;
		corridor_width = 300;
		scan_start = 0;
		scan_step = 182;
		heading = 0;
		scan_min = 16'd32768;
		close_seen = 0;
		sample_idx = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			pending_typed.push_back(dir_rows[i].typed);
			pending_vals.push_back('{dir_rows[i].mult, dir_rows[i].close});
			send(dir_rows[i].motion, dir_rows[i].range_mm, dir_rows[i].last,
				dir_rows[i].vx, dir_rows[i].vy);
		end

		// zero corridor: nothing is ever in the path
		drain();
		write_reg(REG_CORRIDOR_WIDTH, 16'd0);
		write_reg(3'd5, 16'hFFFF);
		write_reg(3'd7, 16'h0001);
		pending_typed.push_back(1);
		pending_vals.push_back('{16'd32768, 1'b0});
		send(0, 16'd0, 1, 0, 0);

		// random phases under several settings, extremes first
		for (int p = 0; p < 6; p++) begin
			drain();
			case (p)
				0: begin
					write_reg(REG_INVERT_SWEEP, 16'd1);
					write_reg(REG_HEADING_OFFSET, 16'h8000);
					write_reg(REG_CORRIDOR_WIDTH, 16'hFFFF);
					write_reg(REG_SCAN_START, 16'h8000);
					write_reg(REG_SCAN_STEP, 16'h8000);
				end
				1: begin
					write_reg(REG_HEADING_OFFSET, 16'h7FFF);
					write_reg(REG_SCAN_START, 16'h7FFF);
					write_reg(REG_SCAN_STEP, 16'h7FFF);
					write_reg(REG_CORRIDOR_WIDTH, 16'd1);
				end
				default: begin
					write_reg(REG_INVERT_SWEEP, 16'($urandom_range(0, 1)));
					write_reg(REG_HEADING_OFFSET, 16'($urandom));
					write_reg(REG_CORRIDOR_WIDTH, $urandom_range(0, 3) == 0 ?
						16'($urandom) : 16'($urandom_range(50, 1500)));
					write_reg(REG_SCAN_START, 16'($urandom));
					write_reg(REG_SCAN_STEP, 16'($urandom_range(0, 1) ?
						$urandom_range(0, 400) : $urandom));
				end
			endcase
			max_gap = (p == 3) ? 0 : 8;
			if (p == 4) begin
				hold_long = 1;
				for (int k = 0; k < 12; k++) send(0, 16'($urandom_range(0, 800)), 1, 0, 0);
				hold_long = 0;
			end
			random_phase(75);
		end

		drain();
		$display("%0d items in, %0d scan results, %0d in-path samples", n_in, n_out, n_hits);
		$display("covered directed extremes, zero corridor, register extremes, stalls");
		if (errors == 0)
			$display("tb_lidar_corridor_speed_limiter_unit: clean");
		else
			$display("tb_lidar_corridor_speed_limiter_unit: errors");
		$finish;
	end

endmodule
